// ===== hdl/zrt_pkg.sv =====
// Shared constants, payload types and sequencer states for the zigzag row transposer.
`timescale 1ns / 1ps
`default_nettype none

package zrt_pkg;

    localparam int MAX_LEN  = 64;
    localparam int MAX_ROWS = 16;

    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int RAIL_W = $clog2(MAX_ROWS);
    localparam int ROWS_W = 5;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic [ROWS_W-1:0] NUM_ROWS_RESET = ROWS_W'(3);

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_final;
    } item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       out_last;
        logic       overflowed;
    } result_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SEEK,
        S_FETCH,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic             byte_we;
        logic [IDX_W-1:0] byte_addr;
        logic [7:0]       byte_val;
        logic             link_we;
        logic [IDX_W-1:0] link_addr;
        logic [IDX_W-1:0] link_val;
    } list_wr_t;

    typedef struct packed {
        logic [7:0]       byte_val;
        logic [IDX_W-1:0] link_val;
    } list_rd_t;

endpackage

`default_nettype wire

// ===== hdl/zrt_list_mem.sv =====
// Byte store and per-entry link memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module zrt_list_mem
    import zrt_pkg::*;
(
    input  wire logic             clk,
    input  wire list_wr_t         wr,
    input  wire logic [IDX_W-1:0] rd_addr,
    output list_rd_t              rd
);

    logic [7:0]       byte_store_reg [MAX_LEN];
    logic [IDX_W-1:0] link_store_reg [MAX_LEN];
    logic [7:0]       rd_byte_reg;
    logic [IDX_W-1:0] rd_link_reg;

    always_ff @(posedge clk)
    begin
        if (wr.byte_we)
        begin
            byte_store_reg[wr.byte_addr] <= wr.byte_val;
        end
        rd_byte_reg <= byte_store_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.link_we)
        begin
            link_store_reg[wr.link_addr] <= wr.link_val;
        end
        rd_link_reg <= link_store_reg[rd_addr];
    end

    assign rd.byte_val = rd_byte_reg;
    assign rd.link_val = rd_link_reg;

endmodule

`default_nettype wire

// ===== hdl/zigzag_row_transposer_top.sv =====
// Top level of the zigzag row transposer: config port, rail walk, readout sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Message bytes are taken one per cycle while the block is loading; each byte is tagged
// with the current zigzag rail and linked onto that rail's list in the list memory. Up to
// MAX_LEN bytes are kept; later bytes are dropped and every result of that message carries
// overflowed. After the final byte is accepted the block stops taking bytes and reads out:
// a small sequencer steps the rails from 0 upward (at most MAX_ROWS) and walks each rail's
// list through the single read port of the list memory, one read and one output transfer
// per byte; the next byte is read only after the result side has taken the current one.
// Loading resumes in the cycle after the last transfer.
module zigzag_row_transposer_top
    import zrt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,

    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire item_t             item,

    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result
);

    state_t              state_reg, state_next;
    logic [ROWS_W-1:0]   num_rows_reg;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [RAIL_W-1:0]   rail_reg, rail_next;
    logic                up_reg, up_next;
    logic                drop_reg, drop_next;
    logic [MAX_ROWS-1:0] nonempty_reg, nonempty_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [IDX_W-1:0]    head_reg [MAX_ROWS];
    logic [IDX_W-1:0]    tail_reg [MAX_ROWS];
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    logic                accept;
    logic                store;
    logic                res_taken;
    logic [IDX_W-1:0]    fill_idx;
    logic [ROWS_W-1:0]   rows;
    logic [ROWS_W-1:0]   bottom;
    logic [RAIL_W-1:0]   walk_rail;
    logic                walk_up;
    logic [MAX_ROWS-1:0] rail_bit;
    logic                at_tail;
    logic                at_end;
    logic [IDX_W-1:0]    rd_addr;
    list_wr_t            wr;
    list_rd_t            rd;

    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_NUM_ROWS)
        begin
            prdata = DATA_W'(num_rows_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= NUM_ROWS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_NUM_ROWS))
        begin
            num_rows_reg <= pwdata[ROWS_W-1:0];
        end
    end

    assign item_stall   = (state_reg != S_LOAD);
    assign accept       = item_valid && !item_stall;
    assign store        = accept && (fill_reg < CNT_W'(MAX_LEN));
    assign fill_idx     = fill_reg[IDX_W-1:0];
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign res_taken    = res_valid_reg && !result_stall;

    // zigzag walk
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            rows = ROWS_W'(1);
        end
        else if (num_rows_reg > ROWS_W'(MAX_ROWS))
        begin
            rows = ROWS_W'(MAX_ROWS);
        end
        else
        begin
            rows = num_rows_reg;
        end
        bottom = rows - ROWS_W'(1);

        if (rows == ROWS_W'(1))
        begin
            walk_rail = '0;
            walk_up   = 1'b0;
        end
        else if (ROWS_W'(rail_reg) >= bottom)
        begin
            walk_rail = RAIL_W'(bottom - ROWS_W'(1));
            walk_up   = 1'b1;
        end
        else if (rail_reg == '0)
        begin
            walk_rail = RAIL_W'(1);
            walk_up   = 1'b0;
        end
        else if (up_reg)
        begin
            walk_rail = rail_reg - RAIL_W'(1);
            walk_up   = 1'b1;
        end
        else
        begin
            walk_rail = rail_reg + RAIL_W'(1);
            walk_up   = 1'b0;
        end
    end

    assign rail_bit = MAX_ROWS'(1) << rail_reg;
    assign at_tail  = (cur_reg == tail_reg[rail_reg]);
    assign at_end   = at_tail && (nonempty_reg == rail_bit);

    assign wr.byte_we   = store;
    assign wr.byte_addr = fill_idx;
    assign wr.byte_val  = item.char_in;
    assign wr.link_we   = store && nonempty_reg[rail_reg];
    assign wr.link_addr = tail_reg[rail_reg];
    assign wr.link_val  = fill_idx;

    zrt_list_mem u_list_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd      (rd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept && item.is_final)
                begin
                    state_next = S_SEEK;
                end
            end
            S_SEEK:
            begin
                if (nonempty_reg[rail_reg])
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (res_taken)
                begin
                    if (at_end)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (at_tail)
                    begin
                        state_next = S_SEEK;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        fill_next      = fill_reg;
        rail_next      = rail_reg;
        up_next        = up_reg;
        drop_next      = drop_reg;
        nonempty_next  = nonempty_reg;
        cur_next       = cur_reg;
        rd_addr        = cur_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (store)
                begin
                    fill_next     = fill_reg + CNT_W'(1);
                    rail_next     = walk_rail;
                    up_next       = walk_up;
                    nonempty_next = nonempty_reg | rail_bit;
                end
                else if (accept)
                begin
                    drop_next = 1'b1;
                end
                if (accept && item.is_final)
                begin
                    rail_next = '0;
                    up_next   = 1'b0;
                end
            end
            S_SEEK:
            begin
                if (nonempty_reg[rail_reg])
                begin
                    rd_addr  = head_reg[rail_reg];
                    cur_next = head_reg[rail_reg];
                end
                else
                begin
                    rail_next = rail_reg + RAIL_W'(1);
                end
            end
            S_FETCH:
            begin
                res_valid_next      = 1'b1;
                res_next.char_out   = rd.byte_val;
                res_next.out_last   = at_end;
                res_next.overflowed = drop_reg;
            end
            S_HOLD:
            begin
                if (res_taken)
                begin
                    res_valid_next = 1'b0;
                    if (at_tail)
                    begin
                        nonempty_next = nonempty_reg & ~rail_bit;
                        if (at_end)
                        begin
                            fill_next = '0;
                            rail_next = '0;
                            up_next   = 1'b0;
                            drop_next = 1'b0;
                        end
                        else
                        begin
                            rail_next = rail_reg + RAIL_W'(1);
                        end
                    end
                    else
                    begin
                        rd_addr  = rd.link_val;
                        cur_next = rd.link_val;
                    end
                end
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            fill_reg      <= '0;
            rail_reg      <= '0;
            up_reg        <= 1'b0;
            drop_reg      <= 1'b0;
            nonempty_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rail_reg      <= rail_next;
            up_reg        <= up_next;
            drop_reg      <= drop_next;
            nonempty_reg  <= nonempty_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        if (store)
        begin
            if (!nonempty_reg[rail_reg])
            begin
                head_reg[rail_reg] <= fill_idx;
            end
            tail_reg[rail_reg] <= fill_idx;
        end
    end

endmodule

`default_nettype wire
